// ===== rtl/eod_pkg.sv =====
// ----------------------------------------------------------------------------
// eod_pkg
// Shared types and constants of the echo occupancy debouncer.
// ----------------------------------------------------------------------------
package eod_pkg;

  localparam int SLOT_W     = 2;
  localparam int WIDTH_W    = 15;
  localparam int DIST_W     = 14;
  localparam int RUN_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int NUM_THRESH = 4;
  localparam int PROD_W     = 30;
  localparam int FRAC_SHIFT = 16;

  // Speed of sound over two, scaled by 16 for a Q4 distance, in Q16: 0.0343 / 2 * 16 * 65536.
  localparam logic [WIDTH_W-1:0] SPEED_Q16 = 15'd17983;

  localparam logic [RUN_W-1:0] DEBOUNCE_RESET = 4'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SLOT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SLOT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SLOT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SLOT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT  = 3'd4;

  // Per-slot state word kept in the state RAM.
  typedef struct packed {
    logic             last_raw;
    logic [RUN_W-1:0] equal_run;
    logic             stable;
  } slot_state_t;

  localparam int STATE_W = $bits(slot_state_t);

  // Request held in the update stage while its state word is read.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] dist_q4;
    logic              timed;
  } upd_req_t;

endpackage

// ===== rtl/echo_occupancy_debouncer_core.sv =====
// ----------------------------------------------------------------------------
// echo_occupancy_debouncer_core
// Converts echo widths to distances and debounces per-slot occupancy.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while in_stall is low and
// delivers its result through the update stage and the output register. The
// per-slot state (last raw reading, run of equal readings, stable occupancy)
// lives in a SLOTS-entry RAM with a registered read: the read is issued when
// a request is accepted and the write-back happens in the update stage, so a
// request that directly follows one to the same slot takes the written word
// from a forwarding register. Entries never written since reset read as zero
// through per-entry valid bits, so no clearing pass is needed. A request
// whose slot index is not below SLOTS is accepted and dropped without a
// result.
module echo_occupancy_debouncer_core #(
  parameter int SLOTS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [eod_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eod_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [eod_pkg::SLOT_W-1:0]    slot_index,
  input  logic [eod_pkg::WIDTH_W-1:0]   echo_width_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [eod_pkg::SLOT_W-1:0]    slot_out,
  output logic [eod_pkg::DIST_W-1:0]    distance_q4,
  output logic                          timed_out,
  output logic                          raw_occupied,
  output logic                          stable_occupied,
  output logic                          state_changed
);
  import eod_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W:0] SLOTS_LIM = (SLOT_W + 1)'(SLOTS);

  // Configuration registers.
  logic [DIST_W-1:0] thresh [NUM_THRESH];
  logic [RUN_W-1:0]  deb_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_THRESH; i++) begin
        thresh[i] <= '0;
      end
      deb_count <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD_SLOT0: thresh[0] <= cfg_data;
        REG_THRESHOLD_SLOT1: thresh[1] <= cfg_data;
        REG_THRESHOLD_SLOT2: thresh[2] <= cfg_data;
        REG_THRESHOLD_SLOT3: thresh[3] <= cfg_data;
        REG_DEBOUNCE_COUNT:  deb_count <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control.
  upd_req_t          s1;
  logic              s1_valid;
  logic              out_free;
  logic              s1_advance;
  logic              in_take;
  logic              in_range;
  logic [PROD_W-1:0] product;
  logic [DIST_W-1:0] in_dist;

  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && out_free;
  assign in_stall   = s1_valid && !out_free;
  assign in_range   = {1'b0, slot_index} < SLOTS_LIM;
  assign in_take    = in_valid && !in_stall && in_range;

  assign product = PROD_W'(echo_width_us) * PROD_W'(SPEED_Q16);
  assign in_dist = product[FRAC_SHIFT +: DIST_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !s1_advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1.slot    <= slot_index;
      s1.dist_q4 <= in_dist;
      s1.timed   <= (echo_width_us == '0);
    end
  end

  // State RAM, valid bits and forwarding.
  slot_state_t       ram_rdata;
  slot_state_t       wr_state;
  logic              ram_we;
  logic [SLOTS-1:0]  entry_valid;
  logic              byp_valid;
  slot_state_t       byp_data;

  eod_ram #(
    .WIDTH (STATE_W),
    .DEPTH (SLOTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1.slot[AW-1:0]),
    .wdata (wr_state),
    .re    (in_take),
    .raddr (slot_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[s1.slot[AW-1:0]] <= 1'b1;
    end
  end

  // The write that shares the read's clock edge is not seen by the RAM read,
  // so it is captured here and used in its place.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (in_take) begin
      byp_valid <= ram_we && (s1.slot == slot_index);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byp_data <= wr_state;
    end
  end

  // Update stage.
  slot_state_t      cur_state;
  logic             raw;
  logic             changed;
  logic [RUN_W-1:0] run_next;

  always_comb begin
    cur_state = ram_rdata;
    if (!entry_valid[s1.slot[AW-1:0]]) begin
      cur_state = '0;
    end
    if (byp_valid) begin
      cur_state = byp_data;
    end

    wr_state = cur_state;
    changed  = 1'b0;
    run_next = cur_state.equal_run;
    if (s1.timed) begin
      raw = cur_state.last_raw;
    end else begin
      raw = (s1.dist_q4 < thresh[s1.slot]);
      if (raw == cur_state.last_raw) begin
        if (cur_state.equal_run < deb_count) begin
          run_next = cur_state.equal_run + RUN_W'(1);
        end
        if ((run_next >= deb_count) && (raw != cur_state.stable)) begin
          wr_state.stable = raw;
          changed         = 1'b1;
        end
      end else begin
        run_next = '0;
      end
      wr_state.equal_run = run_next;
      wr_state.last_raw  = raw;
    end
    ram_we = s1_advance && !s1.timed;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      slot_out        <= s1.slot;
      distance_q4     <= s1.timed ? '0 : s1.dist_q4;
      timed_out       <= s1.timed;
      raw_occupied    <= raw;
      stable_occupied <= wr_state.stable;
      state_changed   <= changed;
    end
  end

`ifndef ASSERT_OFF
  // A change of the debounced state always follows a real reading.
  a_change_not_timeout: assert property (@(posedge clk) disable iff (rst)
    (out_valid && state_changed) |-> (!timed_out && stable_occupied == raw_occupied))
    else $error("state change reported on a timeout or against the raw reading");

  // A timeout carries no distance.
  a_timeout_zero_dist: assert property (@(posedge clk) disable iff (rst)
    (out_valid && timed_out) |-> (distance_q4 == '0))
    else $error("timeout result with nonzero distance");

  // A write-back only happens while the update stage holds a request.
  a_write_needs_req: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (s1_valid && out_free))
    else $error("state RAM written without a request in the update stage");

  // Forwarded data only comes from a write to an entry that is now valid.
  a_bypass_valid_entry: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && byp_valid) |-> entry_valid[s1.slot[AW-1:0]])
    else $error("forwarded state word for an entry never written");

  // A request held in the update stage is delivered in the next cycle
  // unless the output is stalled.
  a_stage_drains: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_free) |=> out_valid)
    else $error("update stage advanced without producing a result");
`endif

endmodule

// ===== rtl/eod_ram.sv =====
// ----------------------------------------------------------------------------
// eod_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module eod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== verif/tb_echo_occupancy_debouncer_core.sv =====
// ----------------------------------------------------------------------------
// tb_echo_occupancy_debouncer_core
// Self-checking bench for the echo occupancy debouncer. Readings are driven
// through the valid/stall request port with random gaps and output stalls.
// A local per-slot debounce predictor computes each expected result, and
// every delivered result is compared in order against it. Directed edge
// cases run first, then random phases under several register settings.
// ----------------------------------------------------------------------------
module tb_echo_occupancy_debouncer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import eod_pkg::*;

  localparam int NUM_SLOTS   = 4;
  localparam int MAX_WIDTH   = (1 << WIDTH_W) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] dist_q4;
    logic              timed;
    logic              raw;
    logic              stable;
    logic              changed;
  } reading_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SLOT_W-1:0]     slot_index = '0;
  logic [WIDTH_W-1:0]    echo_width_us = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SLOT_W-1:0]     slot_out;
  logic [DIST_W-1:0]     distance_q4;
  logic                  timed_out;
  logic                  raw_occupied;
  logic                  stable_occupied;
  logic                  state_changed;

  // Predictor copy of the per-slot state and of the registers.
  logic [DIST_W-1:0] thresh_cfg [NUM_SLOTS];
  logic [RUN_W-1:0]  debounce_cfg;
  logic              last_raw_q [NUM_SLOTS];
  logic [RUN_W-1:0]  run_len    [NUM_SLOTS];
  logic              stable_occ [NUM_SLOTS];

  reading_result_t expected_readings [$];
  reading_result_t want_r;
  reading_result_t got_r;

  bit no_idle = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int changes_seen = 0;
  int timeouts_sent = 0;
  int cycle_count = 0;

  echo_occupancy_debouncer_core #(
    .SLOTS(NUM_SLOTS)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .slot_index     (slot_index),
    .echo_width_us  (echo_width_us),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .slot_out       (slot_out),
    .distance_q4    (distance_q4),
    .timed_out      (timed_out),
    .raw_occupied   (raw_occupied),
    .stable_occupied(stable_occupied),
    .state_changed  (state_changed)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             expected_readings.size());
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk) begin
    if (rst || no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 27);
    end
  end

  function automatic logic [DIST_W-1:0] echo_to_dist(input int width);
    int unsigned prod;
    prod = int'(width) * int'(SPEED_Q16);
    return DIST_W'(prod >> FRAC_SHIFT);
  endfunction

  // Advances the local slot state by one reading and returns its result.
  function automatic reading_result_t predict_reading(input logic [SLOT_W-1:0] slot,
                                                      input logic [WIDTH_W-1:0] width);
    reading_result_t r;
    logic            raw;
    r      = '0;
    r.slot = slot;
    if (width == '0) begin
      r.timed = 1'b1;
      r.raw   = last_raw_q[slot];
    end else begin
      r.dist_q4 = echo_to_dist(int'(width));
      raw       = (r.dist_q4 < thresh_cfg[slot]);
      if (raw == last_raw_q[slot]) begin
        if (run_len[slot] < debounce_cfg) begin
          run_len[slot] = run_len[slot] + 1'b1;
        end
        if (run_len[slot] >= debounce_cfg && raw != stable_occ[slot]) begin
          stable_occ[slot] = raw;
          r.changed        = 1'b1;
        end
      end else begin
        run_len[slot] = '0;
      end
      last_raw_q[slot] = raw;
      r.raw            = raw;
    end
    r.stable = stable_occ[slot];
    return r;
  endfunction

  function automatic logic [CFG_IDX_W-1:0] thresh_reg(input int s);
    case (s)
      0: return REG_THRESHOLD_SLOT0;
      1: return REG_THRESHOLD_SLOT1;
      2: return REG_THRESHOLD_SLOT2;
      default: return REG_THRESHOLD_SLOT3;
    endcase
  endfunction

  // Tries to pick a width whose distance lands on the requested side of the slot's
  // threshold, often right next to the crossing point.
  function automatic int pick_width(input int s, input bit want_occ);
    int knee;
    int w;
    knee = (int'(thresh_cfg[s]) << FRAC_SHIFT) / int'(SPEED_Q16);
    if (knee > MAX_WIDTH) knee = MAX_WIDTH;
    if (knee < 1) knee = 1;
    w = 1;
    for (int t = 0; t < 8; t++) begin
      if ($urandom_range(0, 3) == 0) begin
        w = knee + int'($urandom_range(0, 4)) - 2;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
      end else if (want_occ) begin
        w = $urandom_range(1, (knee < MAX_WIDTH) ? knee + 1 : MAX_WIDTH);
      end else begin
        w = $urandom_range(knee, MAX_WIDTH);
      end
      if ((echo_to_dist(w) < thresh_cfg[s]) == want_occ) return w;
    end
    return w;
  endfunction

  function automatic string fmt_reading(input reading_result_t r);
    return $sformatf("slot=%0d dist=%0d timeout=%0b raw=%0b stable=%0b changed=%0b",
                     r.slot, r.dist_q4, r.timed, r.raw, r.stable, r.changed);
  endfunction

  task automatic report_failure(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Sends one reading and records its expected result once accepted.
  task automatic send_reading(input int slot, input int width);
    reading_result_t r;
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    slot_index    <= SLOT_W'(slot);
    echo_width_us <= WIDTH_W'(width);
    do @(posedge clk); while (in_stall);
    r = predict_reading(SLOT_W'(slot), WIDTH_W'(width));
    expected_readings.push_back(r);
    items_sent++;
    if (r.changed) changes_seen++;
    if (r.timed) timeouts_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx < NUM_THRESH) begin
      thresh_cfg[idx[SLOT_W-1:0]] = data;
    end else if (idx == REG_DEBOUNCE_COUNT) begin
      debounce_cfg = data[RUN_W-1:0];
    end
    cfg_writes++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      got_r = '{slot_out, distance_q4, timed_out, raw_occupied, stable_occupied,
                state_changed};
      if (expected_readings.size() == 0) begin
        report_failure($sformatf("result with nothing expected: %s", fmt_reading(got_r)));
      end else begin
        want_r = expected_readings.pop_front();
        if (got_r !== want_r) begin
          report_failure($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                                   results_seen, fmt_reading(want_r), fmt_reading(got_r)));
        end
      end
    end
  end

  // Default registers: every threshold is zero, so nothing reads occupied.
  task automatic test_after_reset();
    send_reading(0, 0);
    send_reading(1, 1);
    send_reading(2, MAX_WIDTH);
    send_reading(3, 30000);
    send_reading(3, 30001);
    wait_drained();
  endtask

  // Threshold extremes and the exact crossing of slot 2 at distance 100.
  task automatic test_threshold_edges();
    write_reg(REG_THRESHOLD_SLOT0, 14'h3FFF);
    write_reg(REG_THRESHOLD_SLOT1, 14'd0);
    write_reg(REG_THRESHOLD_SLOT2, 14'd100);
    write_reg(REG_THRESHOLD_SLOT3, 14'd8991);
    write_reg(REG_DEBOUNCE_COUNT, 14'd1);
    // An index past the register list must leave everything as it is.
    write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 14'h2AAA);
    send_reading(2, 364);
    send_reading(2, 364);
    send_reading(2, 365);
    send_reading(2, 0);
    send_reading(0, MAX_WIDTH);
    send_reading(1, 1);
    send_reading(3, MAX_WIDTH);
    send_reading(3, MAX_WIDTH - 1);
    wait_drained();
  endtask

  // A debounce count of zero lets any repeated reading apply at once.
  task automatic test_zero_count();
    write_reg(REG_DEBOUNCE_COUNT, 14'h3FF0);
    send_reading(2, 364);
    send_reading(2, 365);
    send_reading(2, 365);
    send_reading(2, 364);
    send_reading(2, 364);
    wait_drained();
  endtask

  // A run built under a large count still counts once the count is lowered.
  task automatic test_lowered_count();
    write_reg(REG_DEBOUNCE_COUNT, 14'd15);
    for (int k = 0; k < 6; k++) send_reading(0, $urandom_range(1, MAX_WIDTH));
    wait_drained();
    write_reg(REG_DEBOUNCE_COUNT, 14'd2);
    send_reading(0, 1000);
    wait_drained();
  endtask

  // Mostly runs of readings aimed at one side of a slot's threshold, mixed
  // with timeouts, readings for other slots and fully random widths.
  task automatic test_random_phase(input int n_items, input int deb, input bit extremes,
                                   input bit quiet);
    int start;
    int slot;
    int roll;
    int len;
    int thr;
    bit want;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (extremes) begin
        case ($urandom_range(0, 3))
          0: thr = 0;
          1: thr = (1 << DIST_W) - 1;
          2: thr = 8991;
          default: thr = 1;
        endcase
      end else begin
        thr = $urandom_range(0, 9200);
      end
      write_reg(thresh_reg(s), CFG_DATA_W'(thr));
    end
    write_reg(REG_DEBOUNCE_COUNT,
              CFG_DATA_W'(($urandom_range(0, (1 << (CFG_DATA_W - RUN_W)) - 1) << RUN_W) | deb));
    write_reg(CFG_IDX_W'($urandom_range(REG_DEBOUNCE_COUNT + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    no_idle = quiet;
    start   = items_sent;
    while (items_sent - start < n_items) begin
      slot = $urandom_range(0, NUM_SLOTS - 1);
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_reading(slot, 0);
      end else if (roll < 20) begin
        send_reading(slot, $urandom_range(1, MAX_WIDTH));
      end else begin
        want = $urandom_range(0, 1);
        len  = $urandom_range(1, int'(debounce_cfg) + 3);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_reading($urandom_range(0, NUM_SLOTS - 1), $urandom_range(0, MAX_WIDTH));
          end
          send_reading(slot, pick_width(slot, want));
        end
      end
    end
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      thresh_cfg[s] = '0;
      last_raw_q[s] = 1'b0;
      run_len[s]    = '0;
      stable_occ[s] = 1'b0;
    end
    debounce_cfg = DEBOUNCE_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_threshold_edges();
    test_zero_count();
    test_lowered_count();
    test_random_phase(190, $urandom_range(1, 15), 1'b0, 1'b0);
    test_random_phase(190, 15, 1'b1, 1'b0);
    test_random_phase(190, 0, 1'b0, 1'b0);
    test_random_phase(190, 1, 1'b0, 1'b1);
    test_random_phase(190, $urandom_range(0, 15), 1'b1, 1'b0);

    repeat (10) @(posedge clk);
    if (expected_readings.size() != 0) begin
      report_failure($sformatf("%0d expected results never arrived",
                               expected_readings.size()));
    end
    $display("Sent %0d readings (%0d timeouts) across %0d register writes;",
             items_sent, timeouts_sent, cfg_writes);
    $display("checked %0d results with %0d debounced changes, %0d failures.",
             results_seen, changes_seen, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== echo_occupancy_debouncer_core.f =====
rtl/eod_pkg.sv
rtl/eod_ram.sv
rtl/echo_occupancy_debouncer_core.sv
verif/tb_echo_occupancy_debouncer_core.sv
